>>> hdl/psp_pkg.sv
`timescale 1ns / 1ps
// Package for the pedal sensor plausibility block: payload structs, widths,
// register indexes, register reset values and sequencing codes. No dependencies.
package psp_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int TIME_W     = 32;
  localparam int POS_W      = 10;
  localparam int PERSIST_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Divider operand widths: 4095 * 1000 needs 22 bits, spans need 12 bits.
  localparam int DIVIDEND_W = 22;
  localparam int DIVISOR_W  = 12;
  localparam int SC_W       = DIVIDEND_W + 1;
  localparam int DIFF_W     = SC_W + 1;

  localparam logic [SAMPLE_W-1:0] RAIL_HIGH  = 12'd4095;
  localparam logic [POS_W-1:0]    POS_FULL   = 10'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MAX      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSIST_MS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND       = 3'd6;

  localparam logic [SAMPLE_W-1:0]  RST_FIRST_MIN      = 12'd400;
  localparam logic [SAMPLE_W-1:0]  RST_FIRST_MAX      = 12'd1500;
  localparam logic [SAMPLE_W-1:0]  RST_SECOND_MIN     = 12'd150;
  localparam logic [SAMPLE_W-1:0]  RST_SECOND_MAX     = 12'd660;
  localparam logic [POS_W-1:0]     RST_MISMATCH_LIMIT = 10'd100;
  localparam logic [PERSIST_W-1:0] RST_PERSIST_MS     = 16'd100;
  localparam logic [POS_W-1:0]     RST_DEADBAND       = 10'd25;

  // Division sequence: the two scaled readings.
  localparam logic OP_SC_ONE = 1'b0;
  localparam logic OP_SC_TWO = 1'b1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_one;
    logic [SAMPLE_W-1:0] sample_two;
    logic [TIME_W-1:0]   now_ms;
  } psp_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average_one;
    logic [SAMPLE_W-1:0] average_two;
    logic [POS_W-1:0]    position;
    logic                fault;
    logic                mismatch_pending;
  } psp_out_t;

endpackage

>>> hdl/psp_div.sv
`timescale 1ns / 1ps
// Shared bit-serial unsigned divider, one quotient bit per cycle.
// Depends on psp_pkg for operand widths.
module psp_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [psp_pkg::DIVIDEND_W-1:0]  dividend_i,
  input  logic [psp_pkg::DIVISOR_W-1:0]   divisor_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [psp_pkg::DIVIDEND_W-1:0]  quotient_o
);

  localparam int CNT_W = $clog2(psp_pkg::DIVIDEND_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(psp_pkg::DIVIDEND_W - 1);

  logic                           busy_q, done_q;
  logic [CNT_W-1:0]               cnt_q;
  logic [psp_pkg::DIVIDEND_W-1:0] quo_q;
  logic [psp_pkg::DIVISOR_W-1:0]  rem_q, dvs_q;
  logic [psp_pkg::DIVISOR_W:0]    trial, diff;
  logic                           ge;

  assign trial = {rem_q, quo_q[psp_pkg::DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = !diff[psp_pkg::DIVISOR_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[psp_pkg::DIVIDEND_W-2:0], ge};
      rem_q <= ge ? diff[psp_pkg::DIVISOR_W-1:0] : trial[psp_pkg::DIVISOR_W-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> hdl/pedal_sensor_plausibility.sv
`timescale 1ns / 1ps
// Each input transfer passes the window update, the average, the shared bit-serial divider
// (two divisions of 22 steps for the scaled readings; a zero span skips its division) and
// the decision. The first item after reset also fills the whole window with its samples.
// One item at a time: the next transfer is taken the cycle after the result is registered,
// and a waiting result holds the block.
// Reset clears the control state, the priming flag and the registers to their defaults.
module pedal_sensor_plausibility #(
  parameter int WINDOW = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  psp_pkg::psp_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output psp_pkg::psp_out_t                 out_data_o,
  input  logic                              cfg_we_i,
  input  logic [psp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [psp_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int SUM_W  = $clog2(WINDOW * 4095 + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SW     = psp_pkg::SAMPLE_W;
  localparam int SC_W   = psp_pkg::SC_W;
  localparam int DIFF_W = psp_pkg::DIFF_W;
  localparam int POS_W  = psp_pkg::POS_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  // The average is taken by reciprocal multiplication, exact for every SUM_W-bit sum.
  localparam int AVG_SH  = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << AVG_SH) + WINDOW - 1) / WINDOW);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FILL   = 3'd1;
  localparam logic [2:0] S_RMW    = 3'd2;
  localparam logic [2:0] S_LOAD   = 3'd3;
  localparam logic [2:0] S_WAIT   = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;
  localparam logic [2:0] S_AVG    = 3'd6;

  logic [2:0]          state_q;
  psp_pkg::psp_in_t    in_q;
  psp_pkg::psp_out_t   out_q;
  logic                out_valid_q;

  logic [SW-1:0]       first_min_q, first_max_q, second_min_q, second_max_q;
  logic [POS_W-1:0]    limit_q, deadband_q;
  logic [psp_pkg::PERSIST_W-1:0] persist_q;

  logic [2*SW-1:0]     mem_q [WINDOW];
  logic [2*SW-1:0]     rdata_q, mem_wdata;
  logic [SLOT_W-1:0]   mem_waddr;
  logic                mem_we;

  logic [SLOT_W-1:0]   slot_q, fill_q;
  logic                primed_q;
  logic [SUM_W-1:0]    sum1_q, sum2_q;
  logic [PROD_W-1:0]   prod1, prod2;
  logic                op_q;
  logic [SW-1:0]       avg1_q, avg2_q;
  logic [SC_W-1:0]     sc1_q, sc2_q;
  logic                neg_q;
  logic                pending_q, fault_q;
  logic [psp_pkg::TIME_W-1:0] start_q;
  logic [POS_W-1:0]    pos_q;

  logic                div_start, div_busy, div_done, div_zero;
  logic [psp_pkg::DIVIDEND_W-1:0] div_dividend, div_quot;
  logic [psp_pkg::DIVISOR_W-1:0]  div_divisor;

  logic [SW-1:0]       cur_avg, cur_min, cur_max;
  logic [SW:0]         off, span;
  logic [SW-1:0]       off_abs, span_abs;
  logic                neg_d;
  logic [SC_W-1:0]     q_ext, sc_val;

  logic [DIFF_W-1:0]   diff_s, diff_abs;
  logic                rail, mismatch, expired, out_free;
  logic [POS_W-1:0]    clamp, pos_acc;
  logic [psp_pkg::TIME_W-1:0] elapsed;
  logic                fault_d, pending_d;
  logic [POS_W-1:0]    pos_d;
  logic [psp_pkg::TIME_W-1:0] start_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  // Window memory: both channels share one word per slot.
  always_comb begin
    mem_we    = (state_q == S_FILL) || (state_q == S_RMW);
    mem_waddr = (state_q == S_FILL) ? fill_q : slot_q;
    mem_wdata = {in_q.sample_two, in_q.sample_one};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[slot_q];
  end

  assign prod1 = PROD_W'(sum1_q) * PROD_W'(RECIP);
  assign prod2 = PROD_W'(sum2_q) * PROD_W'(RECIP);

  // Divider operands for the current step.
  always_comb begin
    cur_avg  = (op_q == psp_pkg::OP_SC_TWO) ? avg2_q : avg1_q;
    cur_min  = (op_q == psp_pkg::OP_SC_TWO) ? second_min_q : first_min_q;
    cur_max  = (op_q == psp_pkg::OP_SC_TWO) ? second_max_q : first_max_q;
    off      = {1'b0, cur_avg} - {1'b0, cur_min};
    span     = {1'b0, cur_max} - {1'b0, cur_min};
    off_abs  = off[SW] ? SW'(-off) : off[SW-1:0];
    span_abs = span[SW] ? SW'(-span) : span[SW-1:0];
    neg_d    = off[SW] ^ span[SW];
    div_dividend = psp_pkg::DIVIDEND_W'(off_abs) * psp_pkg::DIVIDEND_W'(psp_pkg::POS_FULL);
    div_divisor  = span_abs;
    div_zero     = (span_abs == '0);
    div_start = (state_q == S_LOAD) && !div_zero;
    q_ext     = {1'b0, div_quot};
    sc_val    = neg_q ? -q_ext : q_ext;
  end

  psp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Plausibility decision once both scaled readings are in.
  always_comb begin
    diff_s   = {sc1_q[SC_W-1], sc1_q} - {sc2_q[SC_W-1], sc2_q};
    diff_abs = diff_s[DIFF_W-1] ? -diff_s : diff_s;
    mismatch = diff_abs > DIFF_W'(limit_q);
    rail     = (avg1_q == '0) || (avg1_q == psp_pkg::RAIL_HIGH) ||
               (avg2_q == '0) || (avg2_q == psp_pkg::RAIL_HIGH);
    elapsed  = in_q.now_ms - start_q;
    expired  = elapsed > psp_pkg::TIME_W'(persist_q);
    clamp    = (sc1_q[SC_W-2:0] > (SC_W-1)'(psp_pkg::POS_FULL)) ? psp_pkg::POS_FULL
                                                                : sc1_q[POS_W-1:0];
    pos_acc  = (sc1_q[SC_W-1] || (clamp < deadband_q)) ? '0 : clamp;
    fault_d   = fault_q;
    pending_d = pending_q;
    pos_d     = pos_q;
    start_d   = start_q;
    if (rail) begin
      fault_d   = 1'b1;
      pending_d = 1'b0;
      pos_d     = '0;
    end else if (mismatch) begin
      if (!pending_q) begin
        pending_d = 1'b1;
        start_d   = in_q.now_ms;
      end else if (expired) begin
        fault_d   = 1'b1;
        pending_d = 1'b0;
        pos_d     = '0;
      end
    end else begin
      fault_d   = 1'b0;
      pending_d = 1'b0;
      pos_d     = pos_acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      primed_q     <= 1'b0;
      slot_q       <= '0;
      fill_q       <= '0;
      op_q         <= psp_pkg::OP_SC_ONE;
      pending_q    <= 1'b0;
      fault_q      <= 1'b0;
      pos_q        <= '0;
      start_q      <= '0;
      first_min_q  <= psp_pkg::RST_FIRST_MIN;
      first_max_q  <= psp_pkg::RST_FIRST_MAX;
      second_min_q <= psp_pkg::RST_SECOND_MIN;
      second_max_q <= psp_pkg::RST_SECOND_MAX;
      limit_q      <= psp_pkg::RST_MISMATCH_LIMIT;
      persist_q    <= psp_pkg::RST_PERSIST_MS;
      deadband_q   <= psp_pkg::RST_DEADBAND;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          psp_pkg::CFG_FIRST_MIN:      first_min_q  <= cfg_data_i[SW-1:0];
          psp_pkg::CFG_FIRST_MAX:      first_max_q  <= cfg_data_i[SW-1:0];
          psp_pkg::CFG_SECOND_MIN:     second_min_q <= cfg_data_i[SW-1:0];
          psp_pkg::CFG_SECOND_MAX:     second_max_q <= cfg_data_i[SW-1:0];
          psp_pkg::CFG_MISMATCH_LIMIT: limit_q      <= cfg_data_i[POS_W-1:0];
          psp_pkg::CFG_PERSIST_MS:     persist_q    <= cfg_data_i;
          psp_pkg::CFG_DEADBAND:       deadband_q   <= cfg_data_i[POS_W-1:0];
          default: ;
        endcase
      end
      if (state_q == S_DECIDE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            fill_q  <= '0;
            state_q <= primed_q ? S_RMW : S_FILL;
          end
        end
        S_FILL: begin
          fill_q <= fill_q + 1'b1;
          if (fill_q == SLOT_LAST) begin
            primed_q <= 1'b1;
            slot_q   <= '0;
            state_q  <= S_AVG;
          end
        end
        S_RMW: begin
          slot_q  <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
          state_q <= S_AVG;
        end
        S_AVG: begin
          op_q    <= psp_pkg::OP_SC_ONE;
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (div_zero) begin
            op_q    <= psp_pkg::OP_SC_TWO;
            state_q <= (op_q == psp_pkg::OP_SC_TWO) ? S_DECIDE : S_LOAD;
          end else begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_done) begin
            op_q    <= psp_pkg::OP_SC_TWO;
            state_q <= (op_q == psp_pkg::OP_SC_TWO) ? S_DECIDE : S_LOAD;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            fault_q     <= fault_d;
            pending_q   <= pending_d;
            pos_q       <= pos_d;
            start_q     <= start_d;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (state_q == S_FILL && fill_q == SLOT_LAST) begin
      sum1_q <= SUM_W'(in_q.sample_one * WINDOW);
      sum2_q <= SUM_W'(in_q.sample_two * WINDOW);
    end
    if (state_q == S_RMW) begin
      sum1_q <= sum1_q - SUM_W'(rdata_q[SW-1:0]) + SUM_W'(in_q.sample_one);
      sum2_q <= sum2_q - SUM_W'(rdata_q[2*SW-1:SW]) + SUM_W'(in_q.sample_two);
    end
    if (state_q == S_AVG) begin
      avg1_q <= prod1[AVG_SH +: SW];
      avg2_q <= prod2[AVG_SH +: SW];
    end
    if (state_q == S_LOAD) begin
      neg_q <= neg_d;
      if (div_zero) begin
        if (op_q == psp_pkg::OP_SC_ONE) begin
          sc1_q <= '0;
        end else begin
          sc2_q <= '0;
        end
      end
    end
    if (state_q == S_WAIT && div_done) begin
      if (op_q == psp_pkg::OP_SC_ONE) begin
        sc1_q <= sc_val;
      end else begin
        sc2_q <= sc_val;
      end
    end
    if (state_q == S_DECIDE && out_free) begin
      out_q.average_one      <= avg1_q;
      out_q.average_two      <= avg2_q;
      out_q.position         <= pos_d;
      out_q.fault            <= fault_d;
      out_q.mismatch_pending <= pending_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fault_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fault |-> out_data_o.position == '0)
    else $error("Fault reported with a nonzero position.");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.position <= psp_pkg::POS_FULL)
    else $error("Position above full travel.");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_LAST)
    else $error("Write slot beyond the window.");

  a_primed_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    primed_q |=> primed_q)
    else $error("Window lost its primed state.");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("Divider started while busy.");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for pedal_sensor_plausibility: a queue-fed driver, a checking
// monitor and an in-bench predictor of the averaging, scaling and plausibility logic.
// Depends on psp_pkg and the pedal_sensor_plausibility RTL only.
module tb;
  import psp_pkg::*;

  localparam int WIN          = 10;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 148;
  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 150;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  psp_in_t               in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  psp_out_t              out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  pedal_sensor_plausibility #(.WINDOW(WIN)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  int cal_one_lo = RST_FIRST_MIN;
  int cal_one_hi = RST_FIRST_MAX;
  int cal_two_lo = RST_SECOND_MIN;
  int cal_two_hi = RST_SECOND_MAX;
  int diff_limit = RST_MISMATCH_LIMIT;
  logic [TIME_W-1:0] persist_window = RST_PERSIST_MS;
  int dead_zone = RST_DEADBAND;

  logic [SAMPLE_W-1:0] hist_one [WIN];
  logic [SAMPLE_W-1:0] hist_two [WIN];
  int                  total_one = 0;
  int                  total_two = 0;
  int                  slot = 0;
  bit                  primed = 1'b0;
  bit                  timing = 1'b0;
  logic [TIME_W-1:0]   timing_since = '0;
  bit                  fault_q = 1'b0;
  logic [POS_W-1:0]    pos_q = '0;

  psp_in_t  sample_q [$];
  psp_out_t predicted_outputs [$];

  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int fault_results = 0;
  int timing_results = 0;
  int full_results = 0;
  int src_pct = 0;
  int sink_pct = 0;
  int send_gap = 0;
  int sink_gap = 0;
  int hold_left = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int quiet_cycles = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  int src_plan [PHASES]  = '{15, 50, 10, 0, 90, 30, 20, 70, 0};
  int sink_plan [PHASES] = '{15, 30, 10, 0, 20, 60, 20, 10, 0};

  task automatic flag_error(input string what);
    errors++;
    $display("ERROR at %0t: %s", $time, what);
  endtask

  function automatic int scale_pm(input int avg, input int lo, input int hi);
    if (hi == lo) return 0;
    return ((avg - lo) * 1000) / (hi - lo);
  endfunction

  function automatic psp_out_t plausibility_step(input psp_in_t it);
    psp_out_t r;
    int i, avg1, avg2, sc1, sc2, gap, p;
    logic [TIME_W-1:0] elapsed;
    if (!primed) begin
      for (i = 0; i < WIN; i++) begin
        hist_one[i] = it.sample_one;
        hist_two[i] = it.sample_two;
      end
      total_one = int'(it.sample_one) * WIN;
      total_two = int'(it.sample_two) * WIN;
      slot = 0;
      primed = 1'b1;
    end else begin
      total_one = (total_one - int'(hist_one[slot]) + int'(it.sample_one)) & 16'hFFFF;
      total_two = (total_two - int'(hist_two[slot]) + int'(it.sample_two)) & 16'hFFFF;
      hist_one[slot] = it.sample_one;
      hist_two[slot] = it.sample_two;
      slot = (slot + 1 >= WIN) ? 0 : slot + 1;
    end
    avg1 = total_one / WIN;
    avg2 = total_two / WIN;
    sc1 = scale_pm(avg1, cal_one_lo, cal_one_hi);
    sc2 = scale_pm(avg2, cal_two_lo, cal_two_hi);
    gap = (sc1 > sc2) ? sc1 - sc2 : sc2 - sc1;
    if (avg1 == 0 || avg1 >= int'(RAIL_HIGH) || avg2 == 0 || avg2 >= int'(RAIL_HIGH)) begin
      fault_q = 1'b1;
      timing = 1'b0;
      pos_q = '0;
    end else if (gap > diff_limit) begin
      if (!timing) begin
        timing_since = it.now_ms;
        timing = 1'b1;
      end else begin
        elapsed = it.now_ms - timing_since;
        if (elapsed > persist_window) begin
          fault_q = 1'b1;
          timing = 1'b0;
          pos_q = '0;
        end
      end
    end else begin
      p = (sc1 > 1000) ? 1000 : sc1;
      if (p < 0 || p < dead_zone) p = 0;
      timing = 1'b0;
      fault_q = 1'b0;
      pos_q = p[POS_W-1:0];
    end
    r.average_one = avg1[SAMPLE_W-1:0];
    r.average_two = avg2[SAMPLE_W-1:0];
    r.position = pos_q;
    r.fault = fault_q;
    r.mismatch_pending = timing;
    if (fault_q) fault_results++;
    if (timing) timing_results++;
    if (pos_q == POS_FULL) full_results++;
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FIRST_MIN:      cal_one_lo = int'(data[SAMPLE_W-1:0]);
      CFG_FIRST_MAX:      cal_one_hi = int'(data[SAMPLE_W-1:0]);
      CFG_SECOND_MIN:     cal_two_lo = int'(data[SAMPLE_W-1:0]);
      CFG_SECOND_MAX:     cal_two_hi = int'(data[SAMPLE_W-1:0]);
      CFG_MISMATCH_LIMIT: diff_limit = int'(data[POS_W-1:0]);
      CFG_PERSIST_MS:     persist_window = {16'b0, data[PERSIST_W-1:0]};
      CFG_DEADBAND:       dead_zone = int'(data[POS_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic program_phase(input int ph);
    logic [CFG_DATA_W-1:0] fmin, fmax, smin, smax, lim, hold_ms, dz;
    fmin = RST_FIRST_MIN;
    fmax = RST_FIRST_MAX;
    smin = RST_SECOND_MIN;
    smax = RST_SECOND_MAX;
    lim = RST_MISMATCH_LIMIT;
    hold_ms = RST_PERSIST_MS;
    dz = RST_DEADBAND;
    case (ph)
      0: ;
      1: begin
        fmin = 0; fmax = 4095; smin = 4095; smax = 0;
        lim = 50; hold_ms = 0; dz = 0;
      end
      2: begin
        fmin = 2000; fmax = 2000; smin = 300; smax = 3000;
        lim = 1000; hold_ms = 16'hFFFF; dz = 1000;
      end
      3: begin
        fmin = 1000; fmax = 200; smin = 700; smax = 700;
        lim = 0; hold_ms = 20; dz = 10;
      end
      4: begin
        fmin = 16'hA190; fmax = 16'h35DC; smin = 16'hF096; smax = 16'h0294;
        lim = 16'hFFFF; hold_ms = 250; dz = 16'hFFFF;
      end
      6: begin
        fmin = $urandom_range(0, 16'hFFFF); fmax = $urandom_range(0, 16'hFFFF);
        smin = $urandom_range(0, 16'hFFFF); smax = $urandom_range(0, 16'hFFFF);
        lim = $urandom_range(0, 16'hFFFF); hold_ms = $urandom_range(0, 400);
        dz = $urandom_range(0, 16'hFFFF);
      end
      default: begin
        fmin = $urandom_range(0, 4095); fmax = $urandom_range(0, 4095);
        smin = $urandom_range(0, 4095); smax = $urandom_range(0, 4095);
        lim = $urandom_range(0, 1000); hold_ms = $urandom_range(0, 300);
        dz = $urandom_range(0, 100);
      end
    endcase
    write_reg(CFG_FIRST_MIN, fmin);
    write_reg(CFG_FIRST_MAX, fmax);
    write_reg(CFG_SECOND_MIN, smin);
    write_reg(CFG_SECOND_MAX, smax);
    write_reg(CFG_MISMATCH_LIMIT, lim);
    write_reg(CFG_PERSIST_MS, hold_ms);
    write_reg(CFG_DEADBAND, dz);
    write_reg(CFG_NONE, $urandom_range(0, 16'hFFFF));
  endtask

  task automatic queue_sample(input int s1, input int s2, input logic [TIME_W-1:0] t);
    psp_in_t it;
    it.sample_one = s1[SAMPLE_W-1:0];
    it.sample_two = s2[SAMPLE_W-1:0];
    it.now_ms = t;
    sample_q.push_back(it);
  endtask

  function automatic int raw_for(input int pm, input int lo, input int hi);
    int v;
    v = lo + (pm * (hi - lo)) / 1000 + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  // Mostly coherent pedal sweeps with random content; offset runs, rail
  // shorts and plain noise make up the rest.
  task automatic queue_scenarios(input int count);
    int n, i, kind, len, pos, off, rail, s1, s2, r;
    n = 0;
    while (n < count) begin
      kind = $urandom_range(0, 99);
      len = $urandom_range(10, 40);
      pos = int'($urandom_range(0, 1200)) - 100;
      off = 0;
      if (kind >= 60 && kind < 80) begin
        off = int'($urandom_range(50, 700));
        if ($urandom_range(0, 1)) off = -off;
      end
      rail = $urandom_range(0, 1) ? 4095 : 0;
      for (i = 0; i < len && n < count; i++) begin
        pos = pos + int'($urandom_range(0, 60)) - 30;
        s1 = raw_for(pos, cal_one_lo, cal_one_hi);
        s2 = raw_for(pos + off, cal_two_lo, cal_two_hi);
        if (kind >= 80 && kind < 88) begin
          if (kind % 2 == 0) s1 = rail;
          else s2 = rail;
        end else if (kind >= 88) begin
          s1 = $urandom_range(0, 4095);
          s2 = $urandom_range(0, 4095);
        end
        r = $urandom_range(0, 99);
        if (r < 3) clock_ms = $urandom();
        else if (r < 5) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
        else clock_ms = clock_ms + $urandom_range(0, 25);
        queue_sample(s1, s2, clock_ms);
        n++;
      end
    end
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || in_valid_i || predicted_outputs.size() != 0)
      @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predicted_outputs.push_back(plausibility_step(in_data_i));
        items_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (sample_q.size() != 0 && src_pct != 0 &&
                     $urandom_range(0, 99) < src_pct) begin
          send_gap = $urandom_range(0, 6);
          in_valid_i <= 1'b0;
        end else if (sample_q.size() != 0) begin
          in_data_i <= sample_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    psp_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_outputs.size() == 0) begin
          flag_error("result transfer with no prediction waiting");
        end else begin
          want = predicted_outputs.pop_front();
          results_checked++;
          if (out_data_o.average_one !== want.average_one)
            flag_error($sformatf("average_one got %0d want %0d",
                                 out_data_o.average_one, want.average_one));
          if (out_data_o.average_two !== want.average_two)
            flag_error($sformatf("average_two got %0d want %0d",
                                 out_data_o.average_two, want.average_two));
          if (out_data_o.position !== want.position)
            flag_error($sformatf("position got %0d want %0d",
                                 out_data_o.position, want.position));
          if (out_data_o.fault !== want.fault)
            flag_error($sformatf("fault got %b want %b", out_data_o.fault, want.fault));
          if (out_data_o.mismatch_pending !== want.mismatch_pending)
            flag_error($sformatf("mismatch_pending got %b want %b",
                                 out_data_o.mismatch_pending, want.mismatch_pending));
        end
      end
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ready_i <= 1'b0;
      end else if (sink_pct != 0 && $urandom_range(0, 99) < sink_pct) begin
        sink_gap = $urandom_range(0, 6);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int ph;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    src_pct = src_plan[0];
    sink_pct = sink_plan[0];

    // The first pair fills the windows and shorts sensor one to ground.
    queue_sample(0, 405, 32'd100);
    for (int k = 0; k < 10; k++) queue_sample(950, 405, 32'd101 + k);
    for (int k = 0; k < 4; k++) queue_sample(950, 660, 32'd111 + k);
    queue_sample(950, 660, 32'd700);
    // A mismatch timed across the wrap of the millisecond counter.
    queue_sample(950, 660, 32'hFFFF_FFF0);
    queue_sample(950, 660, 32'h0000_0050);
    queue_sample(950, 660, 32'h0000_0060);
    for (int k = 0; k < 3; k++) queue_sample(1600, 700, 32'h61 + k);
    clock_ms = 32'h64;
    wait_drained();

    for (ph = 0; ph < PHASES; ph++) begin
      program_phase(ph);
      @(negedge clk_i);
      src_pct = src_plan[ph];
      sink_pct = sink_plan[ph];
      queue_scenarios(PHASE_ITEMS);
      if (ph == 2) hold_requests++;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (predicted_outputs.size() != 0)
      flag_error($sformatf("%0d predicted results never arrived", predicted_outputs.size()));
    $display("Covered %0d sample pairs under %0d register settings, %0d results checked.",
             items_sent, PHASES + 1, results_checked);
    $display("Results with fault: %0d, with mismatch timing: %0d, at full travel: %0d.",
             fault_results, timing_results, full_results);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/psp_pkg.sv
hdl/psp_div.sv
hdl/pedal_sensor_plausibility.sv
sim/tb.sv
